### design/erpp_pkg.sv
// Shared types and constants for the Euler rotation and projection block.
package erpp_pkg;

   localparam int COORD_BITS_DEFAULT  = 24;
   localparam int SINE_DEPTH_DEFAULT  = 1024;
   localparam int ITEM_QUEUE_DEPTH    = 2;
   localparam int RESULT_QUEUE_DEPTH  = 2;

   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 32;

   localparam int ENTRY_BITS = 32;
   localparam int TRIG_BITS  = 17;

   localparam logic [15:0] SCALE_RESET = 16'd256;

   // matrix builder: trig lookups, products, triples, sums
   localparam int          BUILD_BITS = 4;
   localparam logic [3:0]  BUILD_DONE = 4'd12;

   localparam int TRIG_SX = 0;
   localparam int TRIG_CX = 1;
   localparam int TRIG_SY = 2;
   localparam int TRIG_CY = 3;
   localparam int TRIG_SZ = 4;
   localparam int TRIG_CZ = 5;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ANGLE_X     = 4'd0,
      CSR_ANGLE_Y     = 4'd1,
      CSR_ANGLE_Z     = 4'd2,
      CSR_SCALE       = 4'd3,
      CSR_GAIN        = 4'd4,
      CSR_OFFSET_X    = 4'd5,
      CSR_OFFSET_Y    = 4'd6,
      CSR_USE_PERSP   = 4'd7
   } csr_reg_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MUL,
      BK_SUM,
      BK_SCALE,
      BK_GAIN,
      BK_PERSP,
      BK_PROJ,
      BK_DONE
   } back_state_type;

   typedef logic signed [ENTRY_BITS-1:0] entry_type;
   typedef entry_type [2:0][2:0]         matrix_type;

   typedef struct packed {
      logic [15:0] scale_factor;
      logic [15:0] perspective_gain;
      logic        use_perspective;
   } cfg_type;

endpackage

### design/erpp_sine.sv
// Quarter-wave sine table lookup with quadrant folding; the folded index and sign are registered, then the value.
module erpp_sine import erpp_pkg::*; #(
   parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEFAULT
) (
   input  logic                        clock,
   input  logic [15:0]                 angle,
   output logic signed [TRIG_BITS-1:0] value
);

   localparam int IW = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int AW = $clog2(SINE_TABLE_DEPTH);

   // Q30 Taylor series, evaluated at elaboration
   function automatic logic [15:0] sine_entry(input int unsigned i);
      logic [63:0] x;
      logic [63:0] s;
      logic [63:0] r;
      logic [63:0] t;
      logic [63:0] one;
      one = 64'd1 << 30;
      x = (64'd1686629713 * 64'(i)) / 64'(SINE_TABLE_DEPTH);
      s = (x * x) >> 30;
      r = one;
      for (int n = 7; n >= 1; n--) begin
         t = (s * r) >> 30;
         r = one - t / 64'((2 * n) * (2 * n + 1));
      end
      return 16'((((x * r) >> 30) + 64'd16384) >> 15);
   endfunction

   logic [15:0] rom [SINE_TABLE_DEPTH];

   for (genvar gi = 0; gi < SINE_TABLE_DEPTH; gi++) begin : g_rom
      localparam logic [15:0] VAL = sine_entry(gi);
      assign rom[gi] = VAL;
   end

   logic [31:0]   scaled;
   logic [IW-1:0] idx;
   logic [IW-1:0] k_in;
   logic [IW-1:0] k_ff;
   logic          neg_ff;
   logic [16:0]   mag;

   assign scaled = {18'd0, angle[13:0]} * 32'(SINE_TABLE_DEPTH);
   assign idx    = IW'(scaled >> 14);
   assign k_in   = angle[14] ? IW'(SINE_TABLE_DEPTH) - idx : idx;

   always_comb begin
      if (k_ff >= IW'(SINE_TABLE_DEPTH)) begin
         mag = 17'd32768;
      end else begin
         mag = {1'b0, rom[k_ff[AW-1:0]]};
      end
   end

   always_ff @(posedge clock) begin
      k_ff   <= k_in;
      neg_ff <= angle[15];
      value  <= neg_ff ? -$signed(mag) : $signed(mag);
   end

endmodule

### design/erpp_fifo.sv
// Small synchronous queue used between front and back and on the result side.
module erpp_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             push_ok;
   logic             pop_ok;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign push_ok  = push & ~full;
   assign pop_ok   = pop & ~empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_ok ? AW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop_ok  ? AW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff + CW'(push_ok) - CW'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue count above depth");

endmodule

### design/erpp_front.sv
// Front: config registers, rotation matrix builder and input acceptance.
module erpp_front import erpp_pkg::*; #(
   parameter int COORD_BITS       = COORD_BITS_DEFAULT,
   parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [CSR_DATA_BITS-1:0]    csr_data,
   input  logic                        req_push,
   output logic                        req_full,
   input  logic signed [COORD_BITS-1:0] req_point_x,
   input  logic signed [COORD_BITS-1:0] req_point_y,
   input  logic signed [COORD_BITS-1:0] req_point_z,
   input  logic                        req_first_of_pass,
   output logic                        item_push,
   output logic [3*COORD_BITS:0]       item_data,
   input  logic                        item_full,
   output cfg_type                     cfg,
   output logic signed [COORD_BITS-1:0] offset_x,
   output logic signed [COORD_BITS-1:0] offset_y,
   output matrix_type                  mat
);

   localparam int CB = COORD_BITS;

   logic [15:0]          angle_x_ff, angle_y_ff, angle_z_ff;
   logic [15:0]          scale_ff, gain_ff;
   logic signed [CB-1:0] offset_x_ff, offset_y_ff;
   logic                 use_persp_ff;
   logic                 csr_write;

   logic [BUILD_BITS-1:0] build_ff, build_in;
   logic                  mat_ready;
   logic [15:0]           base_angle;
   logic [15:0]           look_angle;
   logic signed [TRIG_BITS-1:0] sine_value;
   logic signed [TRIG_BITS-1:0] trig_ff [6];

   logic signed [33:0] p_cycz_ff, p_cysz_ff, p_cxsz_ff, p_cxcz_ff, p_sxcy_ff;
   logic signed [33:0] p_sxsz_ff, p_sxcz_ff, p_cxcy_ff, p_sxsy_ff, p_cxsy_ff;
   logic signed [50:0] t_sxsycz_ff, t_sxsysz_ff, t_cxsycz_ff, t_cxsysz_ff;
   logic signed [35:0] r_sxsycz, r_sxsysz, r_cxsycz, r_cxsysz;
   matrix_type         mat_ff;

   function automatic entry_type clamp_entry(input logic signed [35:0] v);
      entry_type r;
      if (v > 36'sd1073741824) begin
         r = 32'sd1073741824;
      end else if (v < -36'sd1073741824) begin
         r = -32'sd1073741824;
      end else begin
         r = 32'(v);
      end
      return r;
   endfunction

   function automatic logic signed [35:0] rnd15(input logic signed [50:0] v);
      return 36'((v + 51'sd16384) >>> 15);
   endfunction

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_x_ff   <= '0;
         angle_y_ff   <= '0;
         angle_z_ff   <= '0;
         scale_ff     <= SCALE_RESET;
         gain_ff      <= '0;
         offset_x_ff  <= '0;
         offset_y_ff  <= '0;
         use_persp_ff <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_reg_type'(csr_index))
            CSR_ANGLE_X:   angle_x_ff   <= csr_data[15:0];
            CSR_ANGLE_Y:   angle_y_ff   <= csr_data[15:0];
            CSR_ANGLE_Z:   angle_z_ff   <= csr_data[15:0];
            CSR_SCALE:     scale_ff     <= csr_data[15:0];
            CSR_GAIN:      gain_ff      <= csr_data[15:0];
            CSR_OFFSET_X:  offset_x_ff  <= csr_data[CB-1:0];
            CSR_OFFSET_Y:  offset_y_ff  <= csr_data[CB-1:0];
            CSR_USE_PERSP: use_persp_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // any register write restarts the matrix build
   always_comb begin
      if (csr_write) begin
         build_in = '0;
      end else if (build_ff != BUILD_DONE) begin
         build_in = build_ff + 1'b1;
      end else begin
         build_in = build_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         build_ff <= '0;
      end else begin
         build_ff <= build_in;
      end
   end

   assign mat_ready = (build_ff == BUILD_DONE);

   // lookup order: sin x, cos x, sin y, cos y, sin z, cos z
   always_comb begin
      case (build_ff[2:1])
         2'd0:    base_angle = angle_x_ff;
         2'd1:    base_angle = angle_y_ff;
         default: base_angle = angle_z_ff;
      endcase
      look_angle = build_ff[0] ? base_angle + 16'h4000 : base_angle;
   end

   erpp_sine #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_sine (
      .clock (clock),
      .angle (look_angle),
      .value (sine_value)
   );

   always_ff @(posedge clock) begin
      if (build_ff >= 4'd2 && build_ff <= 4'd7) begin
         trig_ff[3'(build_ff - 4'd2)] <= sine_value;
      end
   end

   always_ff @(posedge clock) begin
      p_cycz_ff <= trig_ff[TRIG_CY] * trig_ff[TRIG_CZ];
      p_cysz_ff <= trig_ff[TRIG_CY] * trig_ff[TRIG_SZ];
      p_cxsz_ff <= trig_ff[TRIG_CX] * trig_ff[TRIG_SZ];
      p_cxcz_ff <= trig_ff[TRIG_CX] * trig_ff[TRIG_CZ];
      p_sxcy_ff <= trig_ff[TRIG_SX] * trig_ff[TRIG_CY];
      p_sxsz_ff <= trig_ff[TRIG_SX] * trig_ff[TRIG_SZ];
      p_sxcz_ff <= trig_ff[TRIG_SX] * trig_ff[TRIG_CZ];
      p_cxcy_ff <= trig_ff[TRIG_CX] * trig_ff[TRIG_CY];
      p_sxsy_ff <= trig_ff[TRIG_SX] * trig_ff[TRIG_SY];
      p_cxsy_ff <= trig_ff[TRIG_CX] * trig_ff[TRIG_SY];

      t_sxsycz_ff <= p_sxsy_ff * trig_ff[TRIG_CZ];
      t_sxsysz_ff <= p_sxsy_ff * trig_ff[TRIG_SZ];
      t_cxsycz_ff <= p_cxsy_ff * trig_ff[TRIG_CZ];
      t_cxsysz_ff <= p_cxsy_ff * trig_ff[TRIG_SZ];
   end

   assign r_sxsycz = rnd15(t_sxsycz_ff);
   assign r_sxsysz = rnd15(t_sxsysz_ff);
   assign r_cxsycz = rnd15(t_cxsycz_ff);
   assign r_cxsysz = rnd15(t_cxsysz_ff);

   always_ff @(posedge clock) begin
      mat_ff[0][0] <= clamp_entry(36'(p_cycz_ff));
      mat_ff[0][1] <= clamp_entry(-36'(p_cysz_ff));
      mat_ff[0][2] <= clamp_entry(36'(trig_ff[TRIG_SY]) <<< 15);
      mat_ff[1][0] <= clamp_entry(36'(p_cxsz_ff) + r_sxsycz);
      mat_ff[1][1] <= clamp_entry(36'(p_cxcz_ff) - r_sxsysz);
      mat_ff[1][2] <= clamp_entry(-36'(p_sxcy_ff));
      mat_ff[2][0] <= clamp_entry(36'(p_sxsz_ff) - r_cxsycz);
      mat_ff[2][1] <= clamp_entry(36'(p_sxcz_ff) + r_cxsysz);
      mat_ff[2][2] <= clamp_entry(36'(p_cxcy_ff));
   end

   assign mat = mat_ff;

   assign cfg.scale_factor     = scale_ff;
   assign cfg.perspective_gain = gain_ff;
   assign cfg.use_perspective  = use_persp_ff;
   assign offset_x = offset_x_ff;
   assign offset_y = offset_y_ff;

   assign req_full  = ~mat_ready | item_full;
   assign item_push = req_push & ~req_full;
   assign item_data = {req_first_of_pass, req_point_z, req_point_y, req_point_x};

   a_push_needs_matrix: assert property (@(posedge clock) disable iff (reset)
      item_push |-> (build_ff == BUILD_DONE) && !csr_write)
      else $error("point taken while matrix not built");

endmodule

### design/erpp_back.sv
// Back: rotation, scaling, perspective, projection and depth extents per point.
module erpp_back import erpp_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         item_empty,
   input  logic [3*COORD_BITS:0]        item_data,
   output logic                         item_pop,
   input  logic                         res_full,
   output logic                         res_push,
   output logic [8*COORD_BITS-2:0]      res_data,
   input  cfg_type                      cfg,
   input  logic signed [COORD_BITS-1:0] offset_x,
   input  logic signed [COORD_BITS-1:0] offset_y,
   input  matrix_type                   mat
);

   localparam int CB  = COORD_BITS;
   localparam int PW  = ENTRY_BITS + CB;
   localparam int SW  = PW + 2;
   localparam int WB  = CB + 36;
   // wide enough for the factor and for the signed 32-bit limits
   localparam int PVW = (CB + 3 > 33) ? CB + 3 : 33;

   localparam logic signed [WB-1:0] SAT_HI = {{(WB-CB+1){1'b0}}, {(CB-1){1'b1}}};
   localparam logic signed [WB-1:0] SAT_LO = {{(WB-CB+1){1'b1}}, {(CB-1){1'b0}}};
   localparam logic signed [SW-1:0]   HALF30    = SW'(2**29);
   localparam logic signed [CB+16:0]  HALF16_PS = (CB+17)'(2**15);
   localparam logic signed [CB+17:0]  HALF16_PG = (CB+18)'(2**15);
   localparam logic signed [WB-1:0]   HALF16_WB = WB'(2**15);
   localparam logic signed [PVW-1:0]  P_ONE     = PVW'(65536);
   localparam logic signed [PVW-1:0]  P_MAX     = PVW'(2147483647);
   localparam logic signed [PVW-1:0]  P_MIN     = -P_MAX - PVW'(1);

   function automatic logic signed [CB-1:0] sat_cb(input logic signed [WB-1:0] v);
      logic signed [CB-1:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI[CB-1:0];
      end else if (v < SAT_LO) begin
         r = SAT_LO[CB-1:0];
      end else begin
         r = v[CB-1:0];
      end
      return r;
   endfunction

   back_state_type state_ff, state_in;

   logic signed [CB-1:0]   coord_ff [3];
   logic                   first_ff;
   logic signed [PW-1:0]   prod_ff [3][3];
   logic signed [SW-1:0]   sum_w [3];
   logic signed [CB-1:0]   rot_ff [3];
   logic signed [CB+16:0]  ps_ff [3];
   logic signed [CB:0]     pix_w [3];
   logic signed [CB:0]     pix_ff [3];
   logic signed [CB+17:0]  pg_ff;
   logic signed [CB+1:0]   pg_rnd;
   logic signed [PVW-1:0]  pv;
   logic signed [31:0]     persp_ff;
   logic signed [CB+32:0]  q_ff [2];
   logic signed [CB-1:0]   screen_x, screen_y, depth_value;
   logic signed [CB-1:0]   low_ff, high_ff, low_in, high_in;
   logic signed [CB-1:0]   low_base, high_base;

   always_comb begin
      state_in = state_ff;
      item_pop = 1'b0;
      res_push = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            // start only with room for the result
            if (!item_empty && !res_full) begin
               item_pop = 1'b1;
               state_in = BK_MUL;
            end
         end
         BK_MUL:   state_in = BK_SUM;
         BK_SUM:   state_in = BK_SCALE;
         BK_SCALE: state_in = BK_GAIN;
         BK_GAIN:  state_in = BK_PERSP;
         BK_PERSP: state_in = BK_PROJ;
         BK_PROJ:  state_in = BK_DONE;
         BK_DONE: begin
            res_push = 1'b1;
            state_in = BK_IDLE;
         end
         default:  state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_pop) begin
         coord_ff[0] <= item_data[CB-1:0];
         coord_ff[1] <= item_data[2*CB-1:CB];
         coord_ff[2] <= item_data[3*CB-1:2*CB];
         first_ff    <= item_data[3*CB];
      end
   end

   // stages run every cycle; the state machine times when each is valid
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sum_w[i] = SW'(prod_ff[i][0]) + SW'(prod_ff[i][1]) + SW'(prod_ff[i][2]) + HALF30;
         pix_w[i] = (CB+1)'((ps_ff[i] + HALF16_PS) >>> 16);
      end
      pg_rnd = (CB+2)'((pg_ff + HALF16_PG) >>> 16);
      pv     = P_ONE + PVW'(pg_rnd);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            prod_ff[i][j] <= $signed(mat[i][j]) * coord_ff[j];
         end
         rot_ff[i] <= sat_cb(WB'(sum_w[i] >>> 30));
         ps_ff[i]  <= rot_ff[i] * $signed({1'b0, cfg.scale_factor});
         pix_ff[i] <= pix_w[i];
      end
      pg_ff <= pix_w[2] * $signed({1'b0, cfg.perspective_gain});
      if (!cfg.use_perspective) begin
         persp_ff <= 32'sd65536;
      end else if (pv > P_MAX) begin
         persp_ff <= P_MAX[31:0];
      end else if (pv < P_MIN) begin
         persp_ff <= P_MIN[31:0];
      end else begin
         persp_ff <= pv[31:0];
      end
      q_ff[0] <= pix_ff[0] * persp_ff;
      q_ff[1] <= pix_ff[1] * persp_ff;
   end

   assign screen_x    = sat_cb(WB'((WB'(q_ff[0]) + HALF16_WB) >>> 16) + WB'(offset_x));
   assign screen_y    = sat_cb(WB'((WB'(q_ff[1]) + HALF16_WB) >>> 16) + WB'(offset_y));
   assign depth_value = sat_cb(WB'(pix_ff[2]));

   always_comb begin
      low_base  = first_ff ? '0 : low_ff;
      high_base = first_ff ? '0 : high_ff;
      low_in    = (rot_ff[2] < low_base)  ? rot_ff[2] : low_base;
      high_in   = (rot_ff[2] > high_base) ? rot_ff[2] : high_base;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff  <= '0;
         high_ff <= '0;
      end else if (res_push) begin
         low_ff  <= low_in;
         high_ff <= high_in;
      end
   end

   assign res_data = {high_in[CB-2:0], low_in, depth_value, screen_y, screen_x,
                      rot_ff[2], rot_ff[1], rot_ff[0]};

   a_pop_when_idle: assert property (@(posedge clock) disable iff (reset)
      item_pop |-> state_ff == BK_IDLE)
      else $error("item taken while a point is in progress");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      res_push |-> !res_full)
      else $error("result pushed into a full queue");

   a_extent_signs: assert property (@(posedge clock) disable iff (reset)
      !low_ff[CB-1] || low_ff != '0 ? (!high_ff[CB-1]) : 1'b1)
      else $error("depth maximum went negative");

endmodule

### design/euler_rotate_perspective_project_top.sv
// Top level of the Euler XYZ rotation and perspective projection block.
// An accepted beat goes via the item queue and the back sequencer to the
// result queue on the rsp_ ports; a new point starts only once the last
// result is pushed. After reset or any register write req_full stays high
// while the rotation matrix is rebuilt from the sine table; synchronous reset
// loads the register defaults and clears both depth extents and both queues.
module euler_rotate_perspective_project_top import erpp_pkg::*; #(
   parameter int COORD_BITS       = COORD_BITS_DEFAULT,
   parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   output logic                         req_full,
   input  logic signed [COORD_BITS-1:0] req_point_x,
   input  logic signed [COORD_BITS-1:0] req_point_y,
   input  logic signed [COORD_BITS-1:0] req_point_z,
   input  logic                         req_first_of_pass,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output logic signed [COORD_BITS-1:0] rsp_rotated_x,
   output logic signed [COORD_BITS-1:0] rsp_rotated_y,
   output logic signed [COORD_BITS-1:0] rsp_rotated_z,
   output logic signed [COORD_BITS-1:0] rsp_screen_x,
   output logic signed [COORD_BITS-1:0] rsp_screen_y,
   output logic signed [COORD_BITS-1:0] rsp_depth_value,
   output logic signed [COORD_BITS-1:0] rsp_extent_min,
   output logic [COORD_BITS-2:0]        rsp_extent_max,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [CSR_DATA_BITS-1:0]     csr_data
);

   localparam int CB    = COORD_BITS;
   localparam int ITEMW = 3 * CB + 1;
   localparam int RESW  = 8 * CB - 1;

   logic                 item_push, item_full, item_pop, item_empty;
   logic [ITEMW-1:0]     item_in, item_out;
   logic                 res_push, res_full;
   logic [RESW-1:0]      res_in, res_out;
   cfg_type              cfg;
   logic signed [CB-1:0] offset_x, offset_y;
   matrix_type           mat;

   erpp_front #(
      .COORD_BITS       (COORD_BITS),
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_point_x       (req_point_x),
      .req_point_y       (req_point_y),
      .req_point_z       (req_point_z),
      .req_first_of_pass (req_first_of_pass),
      .item_push         (item_push),
      .item_data         (item_in),
      .item_full         (item_full),
      .cfg               (cfg),
      .offset_x          (offset_x),
      .offset_y          (offset_y),
      .mat               (mat)
   );

   erpp_fifo #(.WIDTH(ITEMW), .DEPTH(ITEM_QUEUE_DEPTH)) u_item_q (
      .clock     (clock),
      .reset     (reset),
      .push      (item_push),
      .push_data (item_in),
      .full      (item_full),
      .pop       (item_pop),
      .pop_data  (item_out),
      .empty     (item_empty)
   );

   erpp_back #(.COORD_BITS(COORD_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_empty (item_empty),
      .item_data  (item_out),
      .item_pop   (item_pop),
      .res_full   (res_full),
      .res_push   (res_push),
      .res_data   (res_in),
      .cfg        (cfg),
      .offset_x   (offset_x),
      .offset_y   (offset_y),
      .mat        (mat)
   );

   erpp_fifo #(.WIDTH(RESW), .DEPTH(RESULT_QUEUE_DEPTH)) u_res_q (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_in),
      .full      (res_full),
      .pop       (rsp_pop),
      .pop_data  (res_out),
      .empty     (rsp_empty)
   );

   assign rsp_rotated_x   = res_out[CB-1:0];
   assign rsp_rotated_y   = res_out[2*CB-1:CB];
   assign rsp_rotated_z   = res_out[3*CB-1:2*CB];
   assign rsp_screen_x    = res_out[4*CB-1:3*CB];
   assign rsp_screen_y    = res_out[5*CB-1:4*CB];
   assign rsp_depth_value = res_out[6*CB-1:5*CB];
   assign rsp_extent_min  = res_out[7*CB-1:6*CB];
   assign rsp_extent_max  = res_out[8*CB-2:7*CB];

endmodule

### tb/euler_rotate_perspective_project_top_tb.sv
// Testbench for the Euler rotation and perspective projection block.
module euler_rotate_perspective_project_top_tb import erpp_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CB = COORD_BITS_DEFAULT;
   localparam int SD = SINE_DEPTH_DEFAULT;
   localparam longint ONE30 = 64'sd1 << 30;

   typedef struct {
      logic [CB-1:0] val [8];
   } point_result_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_push;
   logic                  req_full;
   logic signed [CB-1:0]  req_point_x, req_point_y, req_point_z;
   logic                  req_first_of_pass;
   logic                  rsp_empty;
   logic                  rsp_pop;
   logic signed [CB-1:0]  rsp_rotated_x, rsp_rotated_y, rsp_rotated_z;
   logic signed [CB-1:0]  rsp_screen_x, rsp_screen_y, rsp_depth_value, rsp_extent_min;
   logic [CB-2:0]         rsp_extent_max;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_data;

   euler_rotate_perspective_project_top uut (.*);

   always #2 clock = ~clock;

   // predictor state
   logic [15:0] sine_q15_tbl [SD];
   logic [15:0] ang_x, ang_y, ang_z, scale_q8, gain;
   logic signed [CB-1:0] off_x, off_y;
   logic persp_en;
   longint z_low, z_high;

   point_result_type pending_results [$];
   int  mismatches = 0;
   bit  tx_idle_on = 1'b1;
   bit  rx_stall_on = 1'b1;
   int  rx_stall_left = 0;

   string field_names [8] = '{"rotated_x", "rotated_y", "rotated_z", "screen_x",
                              "screen_y", "depth_value", "extent_min", "extent_max"};

   function automatic longint rnd_sh(longint v, int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint sat_coord(longint v);
      return clip(v, -(64'sd1 <<< (CB - 1)), (64'sd1 <<< (CB - 1)) - 1);
   endfunction

   task automatic fill_sine_table();
      longint unsigned x, s, r;
      for (int i = 0; i < SD; i++) begin
         x = (64'd1686629713 * i) / SD;
         s = (x * x) >> 30;
         r = 64'd1 << 30;
         for (int n = 7; n >= 1; n--)
            r = (64'd1 << 30) - ((s * r) >> 30) / ((2 * n) * (2 * n + 1));
         sine_q15_tbl[i] = 16'((((x * r) >> 30) + (64'd1 << 14)) >> 15);
      end
   endtask

   function automatic longint quarter_wave(longint k);
      return k >= SD ? 64'sd32768 : longint'(sine_q15_tbl[k]);
   endfunction

   function automatic longint sin_of(logic [15:0] a);
      longint k;
      k = (longint'(a[13:0]) * SD) >> 14;
      case (a[15:14])
         2'd0: return quarter_wave(k);
         2'd1: return quarter_wave(SD - k);
         2'd2: return -quarter_wave(k);
         default: return -quarter_wave(SD - k);
      endcase
   endfunction

   function automatic longint rot_row(longint m0, m1, m2, x, y, z);
      return sat_coord(rnd_sh(clip(m0, -ONE30, ONE30) * x + clip(m1, -ONE30, ONE30) * y
                              + clip(m2, -ONE30, ONE30) * z, 30));
   endfunction

   function automatic longint to_screen(longint r, longint p, longint off);
      return sat_coord(rnd_sh(rnd_sh(r * scale_q8, 16) * p, 16) + off);
   endfunction

   // computes one projected point and advances the depth extents
   function automatic point_result_type project_point(longint x, y, z, bit first);
      point_result_type res;
      longint sx, cx, sy, cy, sz, cz, rx, ry, rz, d8, p;
      sx = sin_of(ang_x); cx = sin_of(ang_x + 16'h4000);
      sy = sin_of(ang_y); cy = sin_of(ang_y + 16'h4000);
      sz = sin_of(ang_z); cz = sin_of(ang_z + 16'h4000);
      rx = rot_row(cy * cz, -(cy * sz), sy * 32768, x, y, z);
      ry = rot_row(cx * sz + rnd_sh(sx * sy * cz, 15), cx * cz - rnd_sh(sx * sy * sz, 15),
                   -(sx * cy), x, y, z);
      rz = rot_row(sx * sz - rnd_sh(cx * cz * sy, 15), cz * sx + rnd_sh(cx * sy * sz, 15),
                   cx * cy, x, y, z);
      d8 = rnd_sh(rz * scale_q8, 16);
      p = 65536;
      if (persp_en)
         p = clip(65536 + rnd_sh(d8 * gain, 16), -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1);
      if (first) begin
         z_low = 0;
         z_high = 0;
      end
      if (rz < z_low) z_low = rz;
      if (rz > z_high) z_high = rz;
      res.val[0] = CB'(rx);
      res.val[1] = CB'(ry);
      res.val[2] = CB'(rz);
      res.val[3] = CB'(to_screen(rx, p, off_x));
      res.val[4] = CB'(to_screen(ry, p, off_y));
      res.val[5] = CB'(sat_coord(d8));
      res.val[6] = CB'(z_low);
      res.val[7] = {1'b0, z_high[CB-2:0]};
      return res;
   endfunction

   // result side: random pop with stalls unless rx_stall_on is clear, checks each popped beat
   always @(posedge clock) begin
      point_result_type want;
      logic [CB-1:0] got [8];
      if (!reset && rsp_pop && !rsp_empty) begin
         got = '{rsp_rotated_x, rsp_rotated_y, rsp_rotated_z, rsp_screen_x, rsp_screen_y,
                 rsp_depth_value, rsp_extent_min, {1'b0, rsp_extent_max}};
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat at %0t", $realtime);
         end else begin
            want = pending_results.pop_front();
            for (int f = 0; f < 8; f++)
               if (got[f] !== want.val[f]) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%s: expected %h, got %h at %0t", field_names[f],
                              want.val[f], got[f], $realtime);
               end
         end
      end
      if (!rx_stall_on) begin
         rsp_pop <= 1'b1;
      end else if (rx_stall_left > 0) begin
         rx_stall_left--;
         rsp_pop <= 1'b0;
      end else if ($urandom_range(0, 99) < 65) begin
         rsp_pop <= 1'b1;
      end else begin
         rx_stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(0, 3);
         rsp_pop <= 1'b0;
      end
   end

   task automatic send_point(logic [CB-1:0] x, y, z, bit first);
      req_push <= 1'b1;
      req_point_x <= x;
      req_point_y <= y;
      req_point_z <= z;
      req_first_of_pass <= first;
      do @(posedge clock); while (req_full);
      pending_results.insert(pending_results.size(),
                             project_point(signed'(x), signed'(y), signed'(z), first));
   endtask

   task automatic tx_gap();
      int n;
      n = 0;
      if (tx_idle_on) begin
         n = $urandom_range(0, 99);
         n = n < 50 ? 0 : (n < 92 ? $urandom_range(1, 3) : $urandom_range(10, 40));
      end
      if (n > 0) begin
         req_push <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_push <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_ANGLE_X:   ang_x = data[15:0];
         CSR_ANGLE_Y:   ang_y = data[15:0];
         CSR_ANGLE_Z:   ang_z = data[15:0];
         CSR_SCALE:     scale_q8 = data[15:0];
         CSR_GAIN:      gain = data[15:0];
         CSR_OFFSET_X:  off_x = data[CB-1:0];
         CSR_OFFSET_Y:  off_y = data[CB-1:0];
         CSR_USE_PERSP: persp_en = data[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   function automatic logic [CB-1:0] pick_coord();
      case ($urandom_range(0, 5))
         0: return {1'b0, {(CB-1){1'b1}}};
         1: return {1'b1, {(CB-1){1'b0}}};
         2, 3: return CB'($urandom_range(0, 1 << 18)) - CB'(1 << 17);
         default: return CB'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_word();
      case ($urandom_range(0, 5))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic test_identity_extremes();
      logic [CB-1:0] hi, lo;
      hi = {1'b0, {(CB-1){1'b1}}};
      lo = {1'b1, {(CB-1){1'b0}}};
      send_point(hi, hi, hi, 1'b1);
      send_point(lo, lo, lo, 1'b0);
      send_point('0, '0, '0, 1'b0);
      send_point({CB{1'b1}}, 24'h010000, lo, 1'b1);
      drain();
      write_reg(CSR_SCALE, 32'hFFFF);
      write_reg(CSR_OFFSET_X, 32'h7FFFFF);
      write_reg(CSR_OFFSET_Y, 32'h800000);
      send_point(hi, lo, hi, 1'b0);
      send_point(lo, hi, lo, 1'b0);
      drain();
   endtask

   task automatic test_quadrant_angles();
      logic [15:0] angles [6] = '{16'h4000, 16'h8000, 16'hC000, 16'hFFFF, 16'h3FFF, 16'h2000};
      write_reg(CSR_SCALE, 32'h0100);
      write_reg(CSR_OFFSET_X, 32'h0);
      write_reg(CSR_OFFSET_Y, 32'h0);
      for (int i = 0; i < 6; i++) begin
         drain();
         write_reg(CSR_ANGLE_X, angles[i]);
         write_reg(CSR_ANGLE_Y, angles[(i + 1) % 6]);
         write_reg(CSR_ANGLE_Z, angles[(i + 2) % 6]);
         send_point(24'h010000, 24'hFF0000, 24'h7FFFFF, i == 0);
         send_point(24'h800000, 24'h123456, 24'h000001, 1'b0);
      end
      drain();
   endtask

   task automatic test_perspective();
      write_reg(CSR_USE_PERSP, 32'h1);
      write_reg(CSR_GAIN, 32'hFFFF);
      write_reg(CSR_SCALE, 32'hFFFF);
      send_point(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b1);
      send_point(24'h800000, 24'h800000, 24'h800000, 1'b0);
      send_point(24'h000100, 24'hFFFF00, 24'h400000, 1'b0);
      drain();
      // index past the last register must be ignored
      write_reg(CSR_INDEX_BITS'(CSR_USE_PERSP) + 1, 32'hFFFFFFFF);
      write_reg({CSR_INDEX_BITS{1'b1}}, 32'h0);
      send_point(24'h7FFFFF, 24'h000000, 24'h800000, 1'b1);
      drain();
   endtask

   task automatic test_random_phases();
      for (int ph = 0; ph < 20; ph++) begin
         drain();
         write_reg(CSR_ANGLE_X, pick_word());
         write_reg(CSR_ANGLE_Y, pick_word());
         write_reg(CSR_ANGLE_Z, pick_word());
         write_reg(CSR_SCALE, ($urandom_range(0, 3) == 0) ? pick_word()
                                                           : $urandom_range(0, 1024));
         write_reg(CSR_GAIN, pick_word());
         write_reg(CSR_OFFSET_X, ($urandom_range(0, 3) == 0) ? pick_coord() : $urandom);
         write_reg(CSR_OFFSET_Y, ($urandom_range(0, 3) == 0) ? pick_coord() : $urandom);
         write_reg(CSR_USE_PERSP, $urandom);
         tx_idle_on = (ph % 5) != 3;
         rx_stall_on = (ph % 7) != 4;
         for (int i = 0; i < 84; i++) begin
            send_point(pick_coord(), pick_coord(), pick_coord(),
                       i == 0 || $urandom_range(0, 19) == 0);
            tx_gap();
         end
      end
      tx_idle_on = 1'b1;
      rx_stall_on = 1'b1;
      drain();
   endtask

   initial begin
      fill_sine_table();
      ang_x = '0; ang_y = '0; ang_z = '0;
      scale_q8 = SCALE_RESET; gain = '0;
      off_x = '0; off_y = '0; persp_en = 1'b0;
      z_low = 0; z_high = 0;
      reset <= 1'b1;
      req_push <= 1'b0;
      req_point_x <= '0;
      req_point_y <= '0;
      req_point_z <= '0;
      req_first_of_pass <= 1'b0;
      rsp_pop <= 1'b0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_data <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_identity_extremes();
      test_quadrant_angles();
      test_perspective();
      test_random_phases();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("Mismatches found");
      $finish;
   end

endmodule

### filelist.f
design/erpp_pkg.sv
design/erpp_sine.sv
design/erpp_fifo.sv
design/erpp_front.sv
design/erpp_back.sv
design/euler_rotate_perspective_project_top.sv
tb/euler_rotate_perspective_project_top_tb.sv
